### hdl/asd_pkg.sv
// asd_pkg: shared constants, register codes and command/status types for
// the ARP scan detector. No dependencies.

package asd_pkg;

   localparam int SOURCE_ENTRIES_DEF = 16;
   localparam int TARGETS_DEF        = 16;
   localparam int TIME_BITS_DEF      = 48;

   localparam int LEN_W      = 12;
   localparam int OP_W       = 16;
   localparam int MAC_W      = 48;
   localparam int IP_W       = 32;
   localparam int NOW_W      = 48;
   localparam int COUNT_W    = 8;
   localparam int WINDOW_W   = 16;
   localparam int REQ_DATA_W = 240;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_DATA_W = 16;

   localparam int LEN_LSB  = 0;
   localparam int OP_LSB   = 12;
   localparam int DMAC_LSB = 28;
   localparam int SMAC_LSB = 76;
   localparam int SIP_LSB  = 124;
   localparam int TIP_LSB  = 156;
   localparam int NOW_LSB  = 188;

   localparam logic [LEN_W-1:0]    MIN_FRAME    = 12'd42;
   localparam logic [OP_W-1:0]     OP_REQUEST   = 16'd1;
   localparam logic [OP_W-1:0]     OP_REPLY     = 16'd2;
   localparam logic [COUNT_W-1:0]  COUNT_ONE    = 8'd1;
   localparam logic [COUNT_W-1:0]  COUNT_MAX    = 8'd255;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd3000;
   localparam logic [COUNT_W-1:0]  ALARM_RESET  = 8'd5;

   typedef enum logic {
      CSR_WINDOW = 1'b0,
      CSR_ALARM  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic load;
      logic src_step;
      logic tgt_start;
      logic tgt_step;
      logic update;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic item_ok;
      logic src_last;
      logic found;
      logic tgt_done;
      logic alarm;
      logic out_free;
   } status_type;

endpackage

### hdl/asd_ctrl.sv
// asd_ctrl: sequencing state machine of the ARP scan detector.
// Depends on asd_pkg; drives asd_datapath through cmd_type/status_type.

module asd_ctrl import asd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output cmd_type    cmd,
   input  status_type sts
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SRC    = 6'b000010,
      ST_DECIDE = 6'b000100,
      ST_TGT    = 6'b001000,
      ST_UPDATE = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SRC;
            end
         end
         ST_SRC: begin
            cmd.src_step = 1'b1;
            if (sts.src_last) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!sts.item_ok) begin
               state_in = ST_IDLE;
            end else if (sts.found) begin
               cmd.tgt_start = 1'b1;
               state_in      = ST_TGT;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_TGT: begin
            cmd.tgt_step = 1'b1;
            if (sts.tgt_done) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (!sts.alarm) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state register not one-hot");
   a_tgt_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TGT && sts.tgt_done) |=> state_ff == ST_UPDATE)
      else $error("target scan did not end in update");
   a_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (state_ff == ST_FINISH && sts.out_free && sts.alarm))
      else $error("alarm emitted outside finish");

endmodule

### hdl/asd_datapath.sv
// asd_datapath: source table, target table memory, scan trackers, config
// registers and output register. Depends on asd_pkg; driven by asd_ctrl.

module asd_datapath import asd_pkg::*; #(
   parameter int SOURCE_ENTRIES     = SOURCE_ENTRIES_DEF,
   parameter int TARGETS_PER_SOURCE = TARGETS_DEF,
   parameter int TIME_BITS          = TIME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  csr_valid,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  cmd_type               cmd,
   output status_type            sts
);

   localparam int SW    = $clog2(SOURCE_ENTRIES);
   localparam int TW    = $clog2(TARGETS_PER_SOURCE);
   localparam int TCW   = $clog2(TARGETS_PER_SOURCE + 1);
   localparam int DEPTH = SOURCE_ENTRIES * TARGETS_PER_SOURCE;
   localparam int AW    = $clog2(DEPTH);

   function automatic logic is_stale(input logic [TIME_BITS-1:0] then_t,
                                     input logic [TIME_BITS-1:0] now_t,
                                     input logic [WINDOW_W-1:0]  win);
      logic [TIME_BITS-1:0] diff;
      diff = now_t - then_t;
      return (now_t > then_t) && (diff > TIME_BITS'(win));
   endfunction

   // configuration
   logic [WINDOW_W-1:0] window_ff;
   logic [COUNT_W-1:0]  thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         thresh_ff <= ALARM_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WINDOW: window_ff <= csr_data;
            CSR_ALARM:  thresh_ff <= csr_data[COUNT_W-1:0];
            default:    ;
         endcase
      end
   end

   // latched transaction
   logic                 ok_ff;
   logic [MAC_W-1:0]     mac_ff;
   logic [IP_W-1:0]      ip_ff;
   logic [TIME_BITS-1:0] now_ff;

   logic [LEN_W-1:0] f_len;
   logic [OP_W-1:0]  f_op;
   assign f_len = req_tdata[LEN_LSB +: LEN_W];
   assign f_op  = req_tdata[OP_LSB +: OP_W];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ok_ff  <= (f_len >= MIN_FRAME) && (f_op == OP_REQUEST || f_op == OP_REPLY);
         mac_ff <= (f_op == OP_REQUEST) ? req_tdata[SMAC_LSB +: MAC_W]
                                        : req_tdata[DMAC_LSB +: MAC_W];
         ip_ff  <= (f_op == OP_REQUEST) ? req_tdata[TIP_LSB +: IP_W]
                                        : req_tdata[SIP_LSB +: IP_W];
         now_ff <= TIME_BITS'(req_tdata[NOW_LSB +: NOW_W]);
      end
   end

   // source table
   logic [SOURCE_ENTRIES-1:0] src_valid_ff, src_valid_in;
   logic [MAC_W-1:0]          src_mac_ff  [SOURCE_ENTRIES];
   logic [TIME_BITS-1:0]      src_time_ff [SOURCE_ENTRIES];
   logic [COUNT_W-1:0]        src_count_ff[SOURCE_ENTRIES];

   logic [SW-1:0]        sidx_ff, ssel_ff, svict_ff, sel_s, rd_s;
   logic                 sfound_ff, sfree_ff, sstale_ff;
   logic [TIME_BITS-1:0] svict_time_ff;

   assign sel_s = sfound_ff ? ssel_ff : svict_ff;
   assign rd_s  = cmd.update ? sel_s : sidx_ff;

   logic                 s_v;
   logic [MAC_W-1:0]     s_mac;
   logic [TIME_BITS-1:0] s_time;
   assign s_v    = src_valid_ff[rd_s];
   assign s_mac  = src_mac_ff[rd_s];
   assign s_time = src_time_ff[rd_s];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sidx_ff   <= '0;
         sfound_ff <= 1'b0;
      end else if (cmd.src_step) begin
         sidx_ff <= sidx_ff + SW'(1);
         if (!sfound_ff && s_v && s_mac == mac_ff) begin
            sfound_ff <= 1'b1;
            ssel_ff   <= sidx_ff;
            sstale_ff <= is_stale(s_time, now_ff, window_ff);
         end
         if (sidx_ff == '0) begin
            svict_ff      <= '0;
            svict_time_ff <= s_time;
            sfree_ff      <= !s_v;
         end else if (!sfree_ff) begin
            if (!s_v) begin
               svict_ff <= sidx_ff;
               sfree_ff <= 1'b1;
            end else if (s_time < svict_time_ff) begin
               svict_ff      <= sidx_ff;
               svict_time_ff <= s_time;
            end
         end
      end
   end

   // target table
   logic [DEPTH-1:0]          tvalid_ff, tvalid_in;
   logic [IP_W+TIME_BITS-1:0] tmem [DEPTH];
   logic [IP_W+TIME_BITS-1:0] tmem_rd_ff;

   logic [AW-1:0]  base;
   logic [TCW-1:0] rd_idx_ff;
   logic [TW-1:0]  chk_idx_ff, tmatch_idx_ff, tvict_ff;
   logic           chk_vld_ff, tmatch_ff, tstale_ff, tfree_ff, rd_done;
   logic [TIME_BITS-1:0] tvict_time_ff;

   assign base    = AW'(sel_s) * AW'(TARGETS_PER_SOURCE);
   assign rd_done = (rd_idx_ff == TCW'(TARGETS_PER_SOURCE));

   logic                 t_v;
   logic [IP_W-1:0]      t_ip;
   logic [TIME_BITS-1:0] t_time;
   assign t_v    = tvalid_ff[base + AW'(chk_idx_ff)];
   assign t_ip   = tmem_rd_ff[IP_W+TIME_BITS-1:TIME_BITS];
   assign t_time = tmem_rd_ff[TIME_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.tgt_start) begin
         rd_idx_ff  <= '0;
         chk_vld_ff <= 1'b0;
         tmatch_ff  <= 1'b0;
      end else if (cmd.tgt_step) begin
         chk_vld_ff <= !rd_done;
         chk_idx_ff <= rd_idx_ff[TW-1:0];
         if (!rd_done) rd_idx_ff <= rd_idx_ff + TCW'(1);
         if (chk_vld_ff) begin
            if (!tmatch_ff && t_v && t_ip == ip_ff) begin
               tmatch_ff     <= 1'b1;
               tmatch_idx_ff <= chk_idx_ff;
               tstale_ff     <= is_stale(t_time, now_ff, window_ff);
            end
            if (chk_idx_ff == '0) begin
               tvict_ff      <= '0;
               tvict_time_ff <= t_time;
               tfree_ff      <= !t_v;
            end else if (!tfree_ff) begin
               if (!t_v) begin
                  tvict_ff <= chk_idx_ff;
                  tfree_ff <= 1'b1;
               end else if (t_time < tvict_time_ff) begin
                  tvict_ff      <= chk_idx_ff;
                  tvict_time_ff <= t_time;
               end
            end
         end
      end
   end

   // update step
   logic [COUNT_W-1:0] cnt, cnt_in, cnt_inc;
   logic               alarm_in, alarm_ff;
   logic [TW-1:0]      tput;
   logic [AW-1:0]      twr_addr;

   assign cnt     = src_count_ff[rd_s];
   assign cnt_inc = cnt + COUNT_W'(1);

   always_comb begin
      cnt_in   = COUNT_ONE;
      alarm_in = 1'b0;
      tput     = '0;
      if (sfound_ff) begin
         tput   = tmatch_ff ? tmatch_idx_ff : tvict_ff;
         cnt_in = cnt;
         if (sstale_ff) begin
            cnt_in = COUNT_ONE;
         end else if (!(tmatch_ff && !tstale_ff) && cnt != COUNT_MAX) begin
            cnt_in   = cnt_inc;
            alarm_in = (cnt_inc == thresh_ff);
         end
      end
   end

   assign twr_addr = base + AW'(tput);

   always_comb begin
      src_valid_in = src_valid_ff;
      tvalid_in    = tvalid_ff;
      if (cmd.update) begin
         src_valid_in[sel_s] = 1'b1;
         if (!sfound_ff) begin
            for (int t = 0; t < TARGETS_PER_SOURCE; t++) begin
               tvalid_in[base + AW'(t)] = 1'b0;
            end
         end
         tvalid_in[twr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_valid_ff <= '0;
         tvalid_ff    <= '0;
         alarm_ff     <= 1'b0;
      end else begin
         src_valid_ff <= src_valid_in;
         tvalid_ff    <= tvalid_in;
         if (cmd.update) alarm_ff <= alarm_in;
         else if (cmd.load) alarm_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         src_mac_ff[sel_s]   <= mac_ff;
         src_time_ff[sel_s]  <= now_ff;
         src_count_ff[sel_s] <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) tmem[twr_addr] <= {ip_ff, now_ff};
      if (cmd.tgt_step && !rd_done) tmem_rd_ff <= tmem[base + AW'(rd_idx_ff[TW-1:0])];
   end

   // result register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) rsp_data_ff <= mac_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign sts.item_ok  = ok_ff;
   assign sts.src_last = (sidx_ff == SW'(SOURCE_ENTRIES - 1));
   assign sts.found    = sfound_ff;
   assign sts.tgt_done = chk_vld_ff && (chk_idx_ff == TW'(TARGETS_PER_SOURCE - 1));
   assign sts.alarm    = alarm_ff;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

endmodule

### hdl/arp_scan_detector.sv
// arp_scan_detector: takes a new item only when idle, after the previous one is done;
// processing time is set by the one-entry-a-cycle scans of the source table
// and, for a known MAC, of the target memory. The alarm is registered at the
// update and sent from the output register once that register is free. Synchronous
// active-high reset clears all valid bits, the controller and the output
// register; config returns to 3000 ms / 5.

module arp_scan_detector import asd_pkg::*; #(
   parameter int SOURCE_ENTRIES     = SOURCE_ENTRIES_DEF,
   parameter int TARGETS_PER_SOURCE = TARGETS_DEF,
   parameter int TIME_BITS          = TIME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // frame_length, arp_opcode, eth_dest_mac, eth_src_mac, sender_ip,
   // target_ip, now_ms, 4 pad bits
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // scanner_mac
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type sts;

   assign csr_ready = 1'b1;

   asd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   asd_datapath #(
      .SOURCE_ENTRIES     (SOURCE_ENTRIES),
      .TARGETS_PER_SOURCE (TARGETS_PER_SOURCE),
      .TIME_BITS          (TIME_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

### tb/sv/arp_scan_detector_tb.sv
`timescale 1ns / 1ps
// arp_scan_detector_tb: directed table then randomised ARP frames, checked against a
// behavioural scan tracker held in the testbench. Depends on asd_pkg and arp_scan_detector.

module arp_scan_detector_tb;
   import asd_pkg::*;

   localparam int NSRC       = 16;
   localparam int NTGT       = 16;
   localparam int HOLD_LEN   = 1500;
   localparam int IDLE_LIMIT = 6000;
   localparam int SETTLE     = 60;

   typedef struct {
      logic [LEN_W-1:0] len;
      logic [OP_W-1:0]  op;
      logic [MAC_W-1:0] dmac;
      logic [MAC_W-1:0] smac;
      logic [IP_W-1:0]  sip;
      logic [IP_W-1:0]  tip;
      logic [NOW_W-1:0] now;
   } frame_type;

   typedef struct {
      frame_type        f;
      bit               typed;
      bit               hit;
      logic [MAC_W-1:0] mac;
   } vector_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 0;
   logic csr_ready;
   csr_index_type csr_index = CSR_WINDOW;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   arp_scan_detector dut (.*);

   always #10 clock = ~clock;

   // tracker state
   bit               src_valid [NSRC];
   logic [MAC_W-1:0] src_mac   [NSRC];
   logic [NOW_W-1:0] src_seen  [NSRC];
   logic [7:0]       src_count [NSRC];
   bit               tgt_valid [NSRC*NTGT];
   logic [IP_W-1:0]  tgt_addr  [NSRC*NTGT];
   logic [NOW_W-1:0] tgt_seen  [NSRC*NTGT];
   logic [15:0]      window_ms = WINDOW_RESET;
   logic [7:0]       alarm_at  = ALARM_RESET;

   logic [MAC_W-1:0] scanner_q [$];
   vector_type       directed [$];
   logic [MAC_W-1:0] mac_pool [20];
   logic [IP_W-1:0]  ip_pool  [40];
   logic [NOW_W-1:0] clock_ms;
   int errors = 0;
   int idle_pct = 0, stall_pct = 0;
   int hold_left = 0;
   bit hold_ask = 0;
   int quiet = 0;

   function automatic bit is_stale(logic [NOW_W-1:0] seen, logic [NOW_W-1:0] now);
      return now > seen && (now - seen) > window_ms;
   endfunction

   function automatic void record_target(int s, logic [IP_W-1:0] ip, logic [NOW_W-1:0] now);
      int base = s * NTGT;
      int pick = 0;
      bit got_free = 0;
      for (int t = 0; t < NTGT; t++)
         if (tgt_valid[base+t] && tgt_addr[base+t] == ip) begin
            tgt_seen[base+t] = now;
            return;
         end
      for (int t = 0; t < NTGT; t++) begin
         if (!tgt_valid[base+t]) begin
            if (!got_free) begin
               pick = t;
               got_free = 1;
            end
         end else if (!got_free && tgt_seen[base+t] < tgt_seen[base+pick]) begin
            pick = t;
         end
      end
      tgt_valid[base+pick] = 1;
      tgt_addr[base+pick] = ip;
      tgt_seen[base+pick] = now;
   endfunction

   // returns 1 and the MAC when the frame raises an alarm
   function automatic bit track_frame(frame_type f, output logic [MAC_W-1:0] mac);
      logic [IP_W-1:0] ip;
      int pick = 0;
      bit found = 0, got_free = 0, alarm = 0, fresh;
      if (f.len < MIN_FRAME) return 0;
      if (f.op == OP_REQUEST) begin
         mac = f.smac;
         ip = f.tip;
      end else if (f.op == OP_REPLY) begin
         mac = f.dmac;
         ip = f.sip;
      end else begin
         return 0;
      end
      for (int s = 0; s < NSRC; s++)
         if (!found && src_valid[s] && src_mac[s] == mac) begin
            pick = s;
            found = 1;
         end
      if (found) begin
         if (is_stale(src_seen[pick], f.now)) begin
            src_count[pick] = COUNT_ONE;
         end else begin
            fresh = 0;
            for (int t = 0; t < NTGT; t++)
               if (tgt_valid[pick*NTGT+t] && tgt_addr[pick*NTGT+t] == ip) begin
                  fresh = !is_stale(tgt_seen[pick*NTGT+t], f.now);
                  break;
               end
            if (!fresh && src_count[pick] != COUNT_MAX) begin
               src_count[pick]++;
               alarm = (src_count[pick] == alarm_at);
            end
         end
         record_target(pick, ip, f.now);
         src_seen[pick] = f.now;
      end else begin
         for (int s = 0; s < NSRC; s++) begin
            if (!src_valid[s]) begin
               if (!got_free) begin
                  pick = s;
                  got_free = 1;
               end
            end else if (!got_free && src_seen[s] < src_seen[pick]) begin
               pick = s;
            end
         end
         for (int t = 0; t < NTGT; t++) tgt_valid[pick*NTGT+t] = 0;
         src_valid[pick] = 1;
         src_mac[pick] = mac;
         src_seen[pick] = f.now;
         src_count[pick] = COUNT_ONE;
         record_target(pick, ip, f.now);
      end
      return alarm;
   endfunction

   task automatic send_frame(vector_type v);
      logic [MAC_W-1:0] mac;
      bit hit;
      req_tdata <= {4'b0, v.f.now, v.f.tip, v.f.sip, v.f.smac, v.f.dmac, v.f.op, v.f.len};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      hit = track_frame(v.f, mac);
      if (v.typed) begin
         if (v.hit) scanner_q.push_back(v.mac);
      end else if (hit) begin
         scanner_q.push_back(mac);
      end
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx == CSR_WINDOW) window_ms = val;
      else alarm_at = val[7:0];
      @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (scanner_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic void add_row(int len, logic [OP_W-1:0] op, logic [MAC_W-1:0] dmac,
                                   logic [MAC_W-1:0] smac, logic [IP_W-1:0] sip,
                                   logic [IP_W-1:0] tip, logic [NOW_W-1:0] now,
                                   bit typed, bit hit, logic [MAC_W-1:0] mac);
      vector_type v;
      v.f = '{len[LEN_W-1:0], op, dmac, smac, sip, tip, now};
      v.typed = typed;
      v.hit = hit;
      v.mac = mac;
      directed.push_back(v);
   endfunction

   function automatic frame_type random_frame(int mac_span, int ip_span);
      frame_type f;
      int roll = $urandom_range(99);
      if (roll < 12) begin
         f.len = LEN_W'($urandom_range(0, 2048));
         f.op = OP_W'($urandom);
         f.dmac = MAC_W'({$urandom, $urandom});
         f.smac = MAC_W'({$urandom, $urandom});
         f.sip = $urandom;
         f.tip = $urandom;
         f.now = NOW_W'({$urandom, $urandom}) | 48'd1;
         return f;
      end
      f.len = ($urandom_range(9) == 0) ? 12'd2048 : LEN_W'($urandom_range(42, 2047));
      f.op = $urandom_range(1) ? OP_REQUEST : OP_REPLY;
      f.dmac = MAC_W'({$urandom, $urandom});
      f.smac = MAC_W'({$urandom, $urandom});
      f.sip = $urandom;
      f.tip = $urandom;
      if (f.op == OP_REQUEST) begin
         f.smac = mac_pool[$urandom_range(mac_span-1)];
         if (ip_span != 0) f.tip = ip_pool[$urandom_range(ip_span-1)];
      end else begin
         f.dmac = mac_pool[$urandom_range(mac_span-1)];
         if (ip_span != 0) f.sip = ip_pool[$urandom_range(ip_span-1)];
      end
      roll = $urandom_range(99);
      if (roll < 8) clock_ms += NOW_W'($urandom_range(window_ms, 2*window_ms + 2));
      else if (roll < 13 && clock_ms > 600) clock_ms -= NOW_W'($urandom_range(1, 500));
      else clock_ms += NOW_W'($urandom_range(0, window_ms/3 + 1));
      f.now = clock_ms;
      return f;
   endfunction

   task automatic run_phase(int count, int mac_span, int ip_span, bit pause_mid);
      vector_type v;
      v.typed = 0;
      for (int i = 0; i < count; i++) begin
         v.f = random_frame(mac_span, ip_span);
         send_frame(v);
         if (pause_mid && i == count/2) drain();
      end
      drain();
   endtask

   // output side: random back-pressure plus a long hold on request
   always @(posedge clock) begin
      if (hold_ask) begin
         hold_left = HOLD_LEN;
         hold_ask = 0;
      end
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (scanner_q.size() == 0) begin
            $error("unexpected transaction: scanner_mac %h", rsp_tdata);
            errors++;
         end else begin
            if (rsp_tdata[MAC_W-1:0] !== scanner_q[0]) begin
               $error("scanner_mac expected %h actual %h", scanner_q[0], rsp_tdata);
               errors++;
            end
            void'(scanner_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet == IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      logic [MAC_W-1:0] all_ones;
      all_ones = '1;
      mac_pool[0] = '0;
      mac_pool[1] = all_ones;
      for (int i = 2; i < 20; i++) mac_pool[i] = MAC_W'({$urandom, $urandom});
      ip_pool[0] = '0;
      ip_pool[1] = '1;
      for (int i = 2; i < 40; i++) ip_pool[i] = $urandom;

      add_row(0,    OP_REQUEST, 0, 48'h1, 0, 1, 1, 1, 0, 0);
      add_row(41,   OP_REPLY,   48'h1, 0, 1, 0, 2, 1, 0, 0);
      add_row(42,   16'd0,      48'h1, 48'h1, 1, 1, 3, 1, 0, 0);
      add_row(2048, 16'hFFFF,   48'h1, 48'h1, 1, 1, 4, 1, 0, 0);
      add_row(60,   16'd3,      48'h1, 48'h1, 1, 1, 5, 1, 0, 0);
      add_row(42,   OP_REQUEST, 0, all_ones, 0, 32'h0,        10, 1, 0, 0);
      add_row(2048, OP_REQUEST, 0, all_ones, 0, 32'hFFFFFFFF, 20, 0, 0, 0);
      add_row(64,   OP_REQUEST, 0, all_ones, 0, 32'd1,        30, 0, 0, 0);
      add_row(64,   OP_REQUEST, 0, all_ones, 0, 32'd2,        40, 0, 0, 0);
      add_row(64,   OP_REQUEST, 0, all_ones, 0, 32'd3,        50, 1, 1, all_ones);
      add_row(64,   OP_REQUEST, 0, all_ones, 0, 32'd3,        60, 0, 0, 0);
      add_row(64,   OP_REQUEST, 0, all_ones, 0, 32'd4,        70, 0, 0, 0);
      add_row(64,   OP_REPLY,   0, all_ones, 32'hFFFFFFFF, 0, 80, 1, 0, 0);
      add_row(64,   OP_REPLY,   0, all_ones, 32'd5, 0,      5000, 0, 0, 0);
      add_row(64,   OP_REPLY,   0, all_ones, 32'd6, 0,      4000, 0, 0, 0);
      add_row(64,   OP_REQUEST, 0, all_ones, 0, 32'd0,      4000, 0, 0, 0);
      add_row(64,   OP_REQUEST, 0, all_ones, 0, 32'd7,      4100, 0, 0, 0);
      add_row(64,   OP_REPLY,   48'h5A5A_A5A5_0F0F, 0, 32'hA5A5A5A5, 0, '1, 0, 0, 0);
      add_row(64,   OP_REPLY,   48'h5A5A_A5A5_0F0F, 0, 32'h5A5A5A5A, 0, 48'd9, 0, 0, 0);

      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (directed[i]) send_frame(directed[i]);
      drain();

      clock_ms = 48'd100000;
      run_phase(150, 6, 12, 0);

      write_csr(CSR_WINDOW, 16'd1);
      write_csr(CSR_ALARM, 16'd1);
      idle_pct = 64;
      run_phase(150, 20, 40, 0);

      write_csr(CSR_WINDOW, 16'd65535);
      write_csr(CSR_ALARM, 16'd255);
      idle_pct = 0;
      stall_pct = 64;
      run_phase(300, 1, 0, 0);

      write_csr(CSR_WINDOW, 16'd500);
      write_csr(CSR_ALARM, 16'hFF02);
      idle_pct = 7;
      stall_pct = 7;
      hold_ask = 1;
      run_phase(200, 20, 24, 0);

      write_csr(CSR_WINDOW, 16'd40000);
      write_csr(CSR_ALARM, 16'd3);
      idle_pct = 0;
      stall_pct = 0;
      run_phase(150, 8, 30, 1);

      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
